// ----- hdl/epcm_pkg.sv -----
`timescale 1ns / 1ps

package epcm_pkg;

    localparam int CHANNELS       = 8;
    localparam int CH_W           = 3;
    localparam int WAVE_RAM_BYTES = 65536;
    localparam int RAM_AW         = 16;
    localparam int ADDR_W         = 27;
    localparam int FRAC_BITS      = 11;
    localparam int SUM_W          = 19;

    localparam logic [1:0] FUNC_REG_WR = 2'd0;
    localparam logic [1:0] FUNC_RAM_WR = 2'd1;
    localparam logic [1:0] FUNC_RAM_RD = 2'd2;
    localparam logic [1:0] FUNC_TICK   = 2'd3;

    localparam logic [11:0] REG_ENV   = 12'd0;
    localparam logic [11:0] REG_PAN   = 12'd1;
    localparam logic [11:0] REG_STPL  = 12'd2;
    localparam logic [11:0] REG_STPH  = 12'd3;
    localparam logic [11:0] REG_LSL   = 12'd4;
    localparam logic [11:0] REG_LSH   = 12'd5;
    localparam logic [11:0] REG_PAGE  = 12'd6;
    localparam logic [11:0] REG_CTRL  = 12'd7;
    localparam logic [11:0] REG_CHOFF = 12'd8;

    localparam logic [7:0]  END_MARK   = 8'hff;
    localparam logic [16:0] SCALE_RST  = 17'd32768;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] offset;
        logic [7:0]  data;
    } t_in_item;

    typedef struct packed {
        logic               is_sample;
        logic [7:0]         read_data;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } t_out_item;

endpackage

// ----- hdl/eight_channel_pcm_sound_generator_top.sv -----
`timescale 1ns / 1ps

// Register writes, RAM writes and ignored requests are done without leaving S_IDLE; a RAM read
// goes through S_RDW and S_DONE, and its result is registered into the output.
// A tick walks the channels: one that is off is skipped, one whose byte and loop byte are both
// end marks stops after S_W2, one that plays runs on to S_MR; with the chip off it goes to S_DONE.
// One request is worked at a time on the shared 17x16 multiplier and single RAM read port.
// After reset every byte of the wave RAM is filled with 0xff before any request is taken.
module eight_channel_pcm_sound_generator_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  epcm_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output epcm_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [16:0]         i_cfg_data
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_RDW  = 11'b00000000010,
        S_CHK  = 11'b00000000100,
        S_W1   = 11'b00000001000,
        S_W2   = 11'b00000010000,
        S_MS   = 11'b00000100000,
        S_ADV  = 11'b00001000000,
        S_ME   = 11'b00010000000,
        S_ML   = 11'b00100000000,
        S_MR   = 11'b01000000000,
        S_DONE = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic [7:0]  r_env   [epcm_pkg::CHANNELS];
    logic [7:0]  r_pan   [epcm_pkg::CHANNELS];
    logic [15:0] r_step  [epcm_pkg::CHANNELS];
    logic [15:0] r_loop  [epcm_pkg::CHANNELS];
    logic [7:0]  r_page  [epcm_pkg::CHANNELS];
    logic [epcm_pkg::ADDR_W-1:0] r_addr [epcm_pkg::CHANNELS];
    logic [epcm_pkg::CHANNELS-1:0] r_chon;
    logic [epcm_pkg::CH_W-1:0] r_sel;
    logic [3:0]  r_bank;
    logic        r_chip_on;
    logic [16:0] r_scale;

    logic [epcm_pkg::RAM_AW-1:0] r_clr;
    logic        r_clearing;

    logic [epcm_pkg::CH_W-1:0] r_ch;
    logic [7:0]  r_samp;
    logic [32:0] r_prod;
    logic [14:0] r_me;
    logic signed [epcm_pkg::SUM_W-1:0] r_lsum, r_rsum;
    logic        r_is_sample;
    logic [7:0]  r_rd;

    logic        r_ovalid;
    epcm_pkg::t_out_item r_out;

    logic        in_acc;
    logic        ram_we;
    logic [epcm_pkg::RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_wdata, ram_rdata;
    logic [16:0] mul_a;
    logic [15:0] mul_b;
    logic [32:0] mul_p;
    logic        last_ch;
    logic        out_free;
    logic signed [epcm_pkg::SUM_W-1:0] part_s;
    logic [13:0] part;

    assign o_in_ready  = (r_state == S_IDLE) && !r_clearing;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign last_ch     = (r_ch == epcm_pkg::CH_W'(epcm_pkg::CHANNELS - 1));
    assign out_free    = !r_ovalid || i_out_ready;

    assign ram_we    = r_clearing || (in_acc && i_in_data.func == epcm_pkg::FUNC_RAM_WR);
    assign ram_waddr = r_clearing ? r_clr
                                  : epcm_pkg::RAM_AW'({r_bank, i_in_data.offset});
    assign ram_wdata = r_clearing ? epcm_pkg::END_MARK : i_in_data.data;

    always_comb begin
        ram_raddr = epcm_pkg::RAM_AW'({r_bank, i_in_data.offset});
        if (r_state == S_CHK) begin
            ram_raddr = r_addr[r_ch][epcm_pkg::ADDR_W-1:epcm_pkg::FRAC_BITS];
        end else if (r_state == S_W1) begin
            ram_raddr = r_loop[r_ch];
        end
    end

    epcm_ram #(
        .WIDTH (8),
        .DEPTH (epcm_pkg::WAVE_RAM_BYTES)
    ) u_wave_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared multiplier: step times scale, then magnitude times envelope, then pan nibbles.
    always_comb begin
        mul_a = r_scale;
        mul_b = r_step[r_ch];
        if (r_state == S_ADV) begin
            mul_a = {10'd0, r_samp[6:0]};
            mul_b = {8'd0, r_env[r_ch]};
        end else if (r_state == S_ME) begin
            mul_a = {2'd0, r_prod[14:0]};
            mul_b = {12'd0, r_pan[r_ch][3:0]};
        end else if (r_state == S_ML) begin
            mul_a = {2'd0, r_me};
            mul_b = {12'd0, r_pan[r_ch][7:4]};
        end
    end
    assign mul_p = mul_a * mul_b;

    assign part   = r_prod[18:5];
    assign part_s = r_samp[7] ? epcm_pkg::SUM_W'($signed({1'b0, part}))
                              : -epcm_pkg::SUM_W'($signed({1'b0, part}));

    function automatic logic signed [15:0] finish_mix(
        input logic signed [epcm_pkg::SUM_W-1:0] v
    );
        logic signed [15:0] s;
        begin
            if (v > epcm_pkg::SUM_W'(32767)) begin
                s = 16'sh7fff;
            end else if (v < -epcm_pkg::SUM_W'(32768)) begin
                s = -16'sh8000;
            end else begin
                s = v[15:0];
            end
            finish_mix = {s[15:6], 6'd0};
        end
    endfunction

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority if (i_in_data.func == epcm_pkg::FUNC_RAM_RD) begin
                        n_state = S_RDW;
                    end else if (i_in_data.func == epcm_pkg::FUNC_TICK) begin
                        n_state = r_chip_on ? S_CHK : S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RDW: n_state = S_DONE;
            S_CHK: begin
                if (r_chon[r_ch]) begin
                    n_state = S_W1;
                end else if (last_ch) begin
                    n_state = S_DONE;
                end
            end
            S_W1: n_state = (ram_rdata == epcm_pkg::END_MARK) ? S_W2 : S_MS;
            S_W2: begin
                if (ram_rdata != epcm_pkg::END_MARK) begin
                    n_state = S_MS;
                end else if (last_ch) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_MS:  n_state = S_ADV;
            S_ADV: n_state = S_ME;
            S_ME:  n_state = S_ML;
            S_ML:  n_state = S_MR;
            S_MR:  n_state = last_ch ? S_DONE : S_CHK;
            S_DONE: n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clr      <= '0;
            r_clearing <= 1'b1;
            r_ovalid   <= 1'b0;
            r_chon     <= '0;
            r_sel      <= '0;
            r_bank     <= '0;
            r_chip_on  <= 1'b0;
            r_scale    <= epcm_pkg::SCALE_RST;
            for (int i = 0; i < epcm_pkg::CHANNELS; i++) begin
                r_env[i]  <= '0;
                r_pan[i]  <= '0;
                r_step[i] <= '0;
                r_loop[i] <= '0;
                r_page[i] <= '0;
                r_addr[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_clearing) begin
                r_clr <= r_clr + epcm_pkg::RAM_AW'(1);
                if (r_clr == {epcm_pkg::RAM_AW{1'b1}}) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cfg_valid) begin
                r_scale <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            if (in_acc) begin
                unique case (i_in_data.func)
                    epcm_pkg::FUNC_REG_WR: begin
                        unique case (i_in_data.offset)
                            epcm_pkg::REG_ENV:  r_env[r_sel] <= i_in_data.data;
                            epcm_pkg::REG_PAN:  r_pan[r_sel] <= i_in_data.data;
                            epcm_pkg::REG_STPL: r_step[r_sel][7:0] <= i_in_data.data;
                            epcm_pkg::REG_STPH: r_step[r_sel][15:8] <= i_in_data.data;
                            epcm_pkg::REG_LSL:  r_loop[r_sel][7:0] <= i_in_data.data;
                            epcm_pkg::REG_LSH:  r_loop[r_sel][15:8] <= i_in_data.data;
                            epcm_pkg::REG_PAGE: begin
                                r_page[r_sel] <= i_in_data.data;
                                if (!r_chon[r_sel]) begin
                                    r_addr[r_sel] <= {i_in_data.data, 19'd0};
                                end
                            end
                            epcm_pkg::REG_CTRL: begin
                                r_chip_on <= i_in_data.data[7];
                                if (i_in_data.data[6]) begin
                                    r_sel <= i_in_data.data[epcm_pkg::CH_W-1:0];
                                end else begin
                                    r_bank <= i_in_data.data[3:0];
                                end
                            end
                            epcm_pkg::REG_CHOFF: begin
                                for (int i = 0; i < epcm_pkg::CHANNELS; i++) begin
                                    r_chon[i] <= !i_in_data.data[i];
                                    if (i_in_data.data[i]) begin
                                        r_addr[i] <= {r_page[i], 19'd0};
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                    epcm_pkg::FUNC_RAM_RD: r_is_sample <= 1'b0;
                    epcm_pkg::FUNC_TICK: begin
                        r_is_sample <= 1'b1;
                        r_ch        <= '0;
                        r_lsum      <= '0;
                        r_rsum      <= '0;
                    end
                    default: ;
                endcase
            end

            unique case (r_state)
                S_RDW: r_rd <= ram_rdata;
                S_CHK: begin
                    if (!r_chon[r_ch]) begin
                        r_ch <= r_ch + 1'b1;
                    end
                end
                S_W1: begin
                    r_samp <= ram_rdata;
                    if (ram_rdata == epcm_pkg::END_MARK) begin
                        r_addr[r_ch] <= {r_loop[r_ch], 11'd0};
                    end
                end
                S_W2: begin
                    r_samp <= ram_rdata;
                    if (ram_rdata == epcm_pkg::END_MARK) begin
                        r_ch <= r_ch + 1'b1;
                    end
                end
                S_MS: r_prod <= mul_p;
                S_ADV: begin
                    r_addr[r_ch] <= r_addr[r_ch] + epcm_pkg::ADDR_W'(r_prod[32:15]);
                    r_prod       <= mul_p;
                end
                S_ME: begin
                    r_me   <= r_prod[14:0];
                    r_prod <= mul_p;
                end
                S_ML: begin
                    r_lsum <= r_lsum + part_s;
                    r_prod <= mul_p;
                end
                S_MR: begin
                    r_rsum <= r_rsum + part_s;
                    r_ch   <= r_ch + 1'b1;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.is_sample <= r_is_sample;
                        r_out.read_data <= r_is_sample ? 8'd0 : r_rd;
                        r_out.left_sample  <= r_is_sample ? finish_mix(r_lsum) : 16'sd0;
                        r_out.right_sample <= r_is_sample ? finish_mix(r_rsum) : 16'sd0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/epcm_ram.sv -----
`timescale 1ns / 1ps

module epcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- tb/eight_channel_pcm_sound_generator_checker.sv -----
`timescale 1ns / 1ps

module eight_channel_pcm_sound_generator_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  epcm_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  epcm_pkg::t_out_item i_out_data,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [16:0]         i_cfg_data,
    output int                  o_pending,
    output int                  o_errors
);

    logic [7:0]        wave_mem [epcm_pkg::WAVE_RAM_BYTES];
    logic [7:0]        voice_env [epcm_pkg::CHANNELS];
    logic [7:0]        voice_pan [epcm_pkg::CHANNELS];
    logic [15:0]       voice_step [epcm_pkg::CHANNELS];
    logic [15:0]       voice_loop [epcm_pkg::CHANNELS];
    logic [7:0]        voice_page [epcm_pkg::CHANNELS];
    logic [epcm_pkg::ADDR_W-1:0] voice_addr [epcm_pkg::CHANNELS];
    logic              voice_on [epcm_pkg::CHANNELS];
    logic [2:0]        sel_voice;
    logic [3:0]        bank;
    logic              chip_en;
    logic [16:0]       rate_scale;
    epcm_pkg::t_out_item expected_results [$];

    assign o_pending = expected_results.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    function automatic logic [15:0] clamp_mix(input int v);
        int c;
        c = v;
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
        return c[15:0] & 16'hffc0;
    endfunction

    task automatic apply_register(input logic [11:0] num, input logic [7:0] d);
        if (num <= epcm_pkg::REG_PAGE && sel_voice >= epcm_pkg::CHANNELS) return;
        case (num)
            epcm_pkg::REG_ENV:  voice_env[sel_voice] = d;
            epcm_pkg::REG_PAN:  voice_pan[sel_voice] = d;
            epcm_pkg::REG_STPL: voice_step[sel_voice][7:0] = d;
            epcm_pkg::REG_STPH: voice_step[sel_voice][15:8] = d;
            epcm_pkg::REG_LSL:  voice_loop[sel_voice][7:0] = d;
            epcm_pkg::REG_LSH:  voice_loop[sel_voice][15:8] = d;
            epcm_pkg::REG_PAGE: begin
                voice_page[sel_voice] = d;
                if (!voice_on[sel_voice]) voice_addr[sel_voice] = {d, 19'd0};
            end
            epcm_pkg::REG_CTRL: begin
                chip_en = d[7];
                if (d[6]) sel_voice = d[2:0];
                else bank = d[3:0];
            end
            epcm_pkg::REG_CHOFF: begin
                for (int i = 0; i < epcm_pkg::CHANNELS; i++) begin
                    voice_on[i] = !d[i];
                    if (!voice_on[i]) voice_addr[i] = {voice_page[i], 19'd0};
                end
            end
            default: ;
        endcase
    endtask

    // Advances every running voice by one sample and returns the mixed pair.
    function automatic epcm_pkg::t_out_item mix_tick();
        epcm_pkg::t_out_item r;
        int lsum, rsum, lv, rv, mag, lp, rp;
        logic [7:0] s;
        logic [63:0] inc;
        lsum = 0;
        rsum = 0;
        if (chip_en) begin
            for (int i = 0; i < epcm_pkg::CHANNELS; i++) begin
                if (!voice_on[i]) continue;
                lv = int'(voice_pan[i][3:0]) * int'(voice_env[i]);
                rv = int'(voice_pan[i][7:4]) * int'(voice_env[i]);
                s = wave_mem[voice_addr[i][26:11]];
                if (s == epcm_pkg::END_MARK) begin
                    voice_addr[i] = {voice_loop[i], 11'd0};
                    s = wave_mem[voice_loop[i]];
                    if (s == epcm_pkg::END_MARK) continue;
                end
                inc = (64'(voice_step[i]) * 64'(rate_scale)) >> 15;
                voice_addr[i] = voice_addr[i] + inc[epcm_pkg::ADDR_W-1:0];
                mag = int'(s[6:0]);
                lp = (mag * lv) >>> 5;
                rp = (mag * rv) >>> 5;
                if (s[7]) begin
                    lsum += lp;
                    rsum += rp;
                end else begin
                    lsum -= lp;
                    rsum -= rp;
                end
            end
        end
        r.is_sample = 1'b1;
        r.read_data = '0;
        r.left_sample = clamp_mix(lsum);
        r.right_sample = clamp_mix(rsum);
        return r;
    endfunction

    always @(posedge i_clk) begin
        epcm_pkg::t_out_item want;
        epcm_pkg::t_out_item res;
        logic [15:0] ram_idx;
        if (!i_rst_n) begin
            for (int a = 0; a < epcm_pkg::WAVE_RAM_BYTES; a++) wave_mem[a] = epcm_pkg::END_MARK;
            for (int i = 0; i < epcm_pkg::CHANNELS; i++) begin
                voice_env[i] = '0;
                voice_pan[i] = '0;
                voice_step[i] = '0;
                voice_loop[i] = '0;
                voice_page[i] = '0;
                voice_addr[i] = '0;
                voice_on[i] = 1'b0;
            end
            sel_voice = '0;
            bank = '0;
            chip_en = 1'b0;
            rate_scale = epcm_pkg::SCALE_RST;
            expected_results.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", 32'(i_out_data), 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.is_sample !== want.is_sample)
                        report("is_sample", 32'(i_out_data.is_sample), 32'(want.is_sample));
                    if (i_out_data.read_data !== want.read_data)
                        report("read_data", 32'(i_out_data.read_data), 32'(want.read_data));
                    if (i_out_data.left_sample !== want.left_sample)
                        report("left_sample", 32'(i_out_data.left_sample),
                               32'(want.left_sample));
                    if (i_out_data.right_sample !== want.right_sample)
                        report("right_sample", 32'(i_out_data.right_sample),
                               32'(want.right_sample));
                end
            end
            if (i_cfg_valid && i_cfg_ready) rate_scale = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                ram_idx = {bank, 12'd0} + 16'(i_in_data.offset);
                case (i_in_data.func)
                    epcm_pkg::FUNC_REG_WR: apply_register(i_in_data.offset, i_in_data.data);
                    epcm_pkg::FUNC_RAM_WR: wave_mem[ram_idx] = i_in_data.data;
                    epcm_pkg::FUNC_RAM_RD: begin
                        res = '0;
                        res.read_data = wave_mem[ram_idx];
                        expected_results.push_back(res);
                    end
                    default: expected_results.push_back(mix_tick());
                endcase
            end
        end
    end

endmodule

// ----- tb/eight_channel_pcm_sound_generator_top_tb.sv -----
`timescale 1ns / 1ps

module eight_channel_pcm_sound_generator_top_tb;

    localparam int IDLE_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    epcm_pkg::t_in_item  in_req = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    epcm_pkg::t_out_item out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_data = '0;
    int          pending;
    int          errors;
    int          idle_cycles = 0;
    int          calm_phase = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    eight_channel_pcm_sound_generator_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_req),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    eight_channel_pcm_sound_generator_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_data  (in_req),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_data (out_item),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (calm_phase != 0) return 0;
        if (r < 55) return 0;
        if (r < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 60));
    endfunction

    // The result side stalls on its own schedule, and is held ready during calm stretches.
    always @(negedge i_clk) begin
        if (calm_phase != 0 || $urandom_range(0, 99) < 65) out_ready <= 1'b1;
        else if ($urandom_range(0, 99) < 90) out_ready <= 1'b0;
        else begin
            out_ready <= 1'b0;
            repeat ($urandom_range(10, 80)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] f, input logic [11:0] off, input logic [7:0] d);
        int gap;
        in_valid = 1'b1;
        in_req.func = f;
        in_req.offset = off;
        in_req.data = d;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic write_scale(input logic [16:0] v);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (100) @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_data = v;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_request();
        int r;
        logic [11:0] num;
        logic [7:0] d;
        r = int'($urandom_range(0, 99));
        d = 8'($urandom_range(0, 255));
        if (r < 45) begin
            send_request(epcm_pkg::FUNC_TICK, 12'($urandom_range(0, 4095)), d);
        end else if (r < 62) begin
            if ($urandom_range(0, 6) == 0) d = epcm_pkg::END_MARK;
            send_request(epcm_pkg::FUNC_RAM_WR, 12'($urandom_range(0, 4095)), d);
        end else if (r < 70) begin
            send_request(epcm_pkg::FUNC_RAM_RD, 12'($urandom_range(0, 4095)), d);
        end else if (r < 96) begin
            num = 12'($urandom_range(0, 8));
            // Keep voices and the bank mostly inside the region that gets written.
            if (num == epcm_pkg::REG_PAGE && $urandom_range(0, 3) != 0)
                d = 8'($urandom_range(0, 31));
            if (num == epcm_pkg::REG_LSH && $urandom_range(0, 3) != 0)
                d = 8'($urandom_range(0, 31));
            if (num == epcm_pkg::REG_CTRL) begin
                if ($urandom_range(0, 4) != 0) d[7] = 1'b1;
                if (!d[6] && $urandom_range(0, 3) != 0) d[3:0] = 4'($urandom_range(0, 1));
            end
            if (num == epcm_pkg::REG_CHOFF && $urandom_range(0, 2) != 0)
                d = d & 8'($urandom_range(0, 255));
            send_request(epcm_pkg::FUNC_REG_WR, num, d);
        end else begin
            send_request(epcm_pkg::FUNC_REG_WR, 12'($urandom_range(9, 4095)), d);
        end
    endtask

    initial begin
        logic [16:0] scales [6];
        scales = '{17'd0, 17'd131071, 17'd32768, 17'd1, 17'd0, 17'd0};
        scales[4] = 17'($urandom_range(0, 131071));
        scales[5] = 17'($urandom_range(16384, 98304));
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset contents, field extremes, chip off, end marks and loops.
        send_request(epcm_pkg::FUNC_RAM_RD, 12'd0, 8'd0);
        send_request(epcm_pkg::FUNC_TICK, 12'd0, 8'd0);
        send_request(epcm_pkg::FUNC_RAM_WR, 12'd0, 8'h00);
        send_request(epcm_pkg::FUNC_RAM_WR, 12'd4095, 8'h80);
        send_request(epcm_pkg::FUNC_RAM_WR, 12'd1, 8'h7f);
        send_request(epcm_pkg::FUNC_RAM_WR, 12'd2, 8'hff);
        send_request(epcm_pkg::FUNC_RAM_RD, 12'd4095, 8'hff);
        send_request(epcm_pkg::FUNC_RAM_RD, 12'd1, 8'd0);
        send_request(epcm_pkg::FUNC_REG_WR, epcm_pkg::REG_CTRL, 8'hc0);
        send_request(epcm_pkg::FUNC_REG_WR, epcm_pkg::REG_ENV, 8'hff);
        send_request(epcm_pkg::FUNC_REG_WR, epcm_pkg::REG_PAN, 8'hff);
        send_request(epcm_pkg::FUNC_REG_WR, epcm_pkg::REG_STPL, 8'hff);
        send_request(epcm_pkg::FUNC_REG_WR, epcm_pkg::REG_STPH, 8'h07);
        send_request(epcm_pkg::FUNC_REG_WR, epcm_pkg::REG_PAGE, 8'h00);
        send_request(epcm_pkg::FUNC_REG_WR, epcm_pkg::REG_CHOFF, 8'hfe);
        send_request(epcm_pkg::FUNC_TICK, 12'd0, 8'd0);
        send_request(epcm_pkg::FUNC_TICK, 12'd0, 8'd0);
        send_request(epcm_pkg::FUNC_TICK, 12'd0, 8'd0);
        send_request(epcm_pkg::FUNC_REG_WR, epcm_pkg::REG_LSH, 8'hff);
        send_request(epcm_pkg::FUNC_REG_WR, epcm_pkg::REG_LSL, 8'hff);
        send_request(epcm_pkg::FUNC_REG_WR, epcm_pkg::REG_PAGE, 8'hff);
        send_request(epcm_pkg::FUNC_TICK, 12'd0, 8'd0);
        send_request(epcm_pkg::FUNC_REG_WR, 12'd9, 8'hff);
        send_request(epcm_pkg::FUNC_REG_WR, epcm_pkg::REG_CHOFF, 8'h00);
        send_request(epcm_pkg::FUNC_TICK, 12'd0, 8'd0);

        foreach (scales[p]) begin
            write_scale(scales[p]);
            calm_phase = (p == 2) ? 1 : 0;
            repeat (215) random_request();
        end
        calm_phase = 0;
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/epcm_pkg.sv
hdl/epcm_ram.sv
hdl/eight_channel_pcm_sound_generator_top.sv
tb/eight_channel_pcm_sound_generator_checker.sv
tb/eight_channel_pcm_sound_generator_top_tb.sv
